FILE: design/lbpm_pkg.sv
// ----------------------------------------------------------------------------
// lbpm_pkg: shared types and constants of the light bar pair matcher
// Bar record, register indexes, reset values and the per-pair step codes.
// ----------------------------------------------------------------------------
package lbpm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW = 16;
  localparam int unsigned AngW = 13;
  localparam int unsigned AngleGapW = 11;
  localparam int unsigned CountW = 9;
  localparam int unsigned MulW = 17;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned RsW = 33;
  localparam int unsigned SqW = 2 * RsW;
  localparam int unsigned SumW = PosW + 1;

  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH_GAP = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ANGLE_GAP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SPACING_RATIO = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPACING_RATIO = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_HEIGHT_RATIO = 3'd4;

  localparam logic [15:0] RST_MAX_LENGTH_GAP = 16'd800;
  localparam logic [10:0] RST_MAX_ANGLE_GAP = 11'd560;
  localparam logic [15:0] RST_MIN_SPACING_RATIO = 16'd154;
  localparam logic [15:0] RST_MAX_SPACING_RATIO = 16'd1280;
  localparam logic [15:0] RST_MAX_HEIGHT_RATIO = 16'd205;

  localparam logic signed [13:0] ANGLE_HALF = 14'sd1440;
  localparam logic signed [13:0] ANGLE_FULL = 14'sd2880;
  localparam logic [CountW-1:0] COUNT_MAX = 9'd511;

  typedef struct packed {
    logic [PosW-1:0]        x;
    logic [PosW-1:0]        y;
    logic [PosW-1:0]        len;
    logic signed [AngW-1:0] ang;
  } bar_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_EVAL,
    STEP_M_DX,
    STEP_M_DY,
    STEP_M_MIN,
    STEP_M_MAX,
    STEP_M_HGT,
    STEP_SQ_MIN_L,
    STEP_SQ_MIN_M,
    STEP_SQ_MIN_H,
    STEP_SQ_MAX_L,
    STEP_SQ_MAX_M,
    STEP_SQ_MAX_H,
    STEP_FINISH
  } step_e;

  typedef struct packed {
    logic  mem_we;
    logic  cnt_clr;
    step_e step;
  } cmd_t;

  function automatic step_e next_step(step_e s);
    step_e n;
    case (s)
      STEP_EVAL:     n = STEP_M_DX;
      STEP_M_DX:     n = STEP_M_DY;
      STEP_M_DY:     n = STEP_M_MIN;
      STEP_M_MIN:    n = STEP_M_MAX;
      STEP_M_MAX:    n = STEP_M_HGT;
      STEP_M_HGT:    n = STEP_SQ_MIN_L;
      STEP_SQ_MIN_L: n = STEP_SQ_MIN_M;
      STEP_SQ_MIN_M: n = STEP_SQ_MIN_H;
      STEP_SQ_MIN_H: n = STEP_SQ_MAX_L;
      STEP_SQ_MAX_L: n = STEP_SQ_MAX_M;
      STEP_SQ_MAX_M: n = STEP_SQ_MAX_H;
      STEP_SQ_MAX_H: n = STEP_FINISH;
      default:       n = STEP_EVAL;
    endcase
    return n;
  endfunction

endpackage

FILE: design/lbpm_datapath.sv
// ----------------------------------------------------------------------------
// lbpm_datapath: bar store, config registers and pair test arithmetic
// Two-read bar memory, one shared 17x17 multiplier and the pair counter.
// ----------------------------------------------------------------------------
module lbpm_datapath #(
  parameter int unsigned MAX_BARS = 32,
  localparam int unsigned AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lbpm_pkg::cmd_t                 cmd_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [AW-1:0]                  raddr_a_i,
  input  logic [AW-1:0]                  raddr_b_i,
  input  logic [lbpm_pkg::PosW-1:0]      center_x_i,
  input  logic [lbpm_pkg::PosW-1:0]      center_y_i,
  input  logic [lbpm_pkg::PosW-1:0]      bar_length_i,
  input  logic signed [lbpm_pkg::AngW-1:0] bar_angle_i,
  input  logic                           cfg_we_i,
  input  logic [lbpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbpm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic [lbpm_pkg::CountW-1:0]    pair_count_o
);

  lbpm_pkg::bar_t mem [MAX_BARS];
  lbpm_pkg::bar_t rd_a_q, rd_b_q;

  logic [15:0] len_gap_q, min_ratio_q, max_ratio_q, hgt_ratio_q;
  logic [lbpm_pkg::AngleGapW-1:0] ang_gap_q;

  logic [lbpm_pkg::SumW-1:0]  sum_q;
  logic [lbpm_pkg::PosW-1:0]  dx_q, dy_q;
  logic [lbpm_pkg::RsW-1:0]   dist_q, rsmin_q, rsmax_q;
  logic [lbpm_pkg::SqW-1:0]   acc_q;
  logic [lbpm_pkg::ProdW-1:0] prod_q;
  logic                       rej_q;
  logic [lbpm_pkg::CountW-1:0] count_q;

  logic [lbpm_pkg::MulW-1:0]  op_a, op_b;
  logic [15:0]                rmax;
  logic [lbpm_pkg::SumW-1:0]  sum_d;
  logic [lbpm_pkg::PosW-1:0]  len_delta, dx_d, dy_d;
  logic signed [13:0]         ang_d, ang_abs, ang_w;
  logic                       first_bad;
  logic [lbpm_pkg::SqW-1:0]   scaled, sq_sum, prod_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[waddr_i] <= '{x: center_x_i, y: center_y_i, len: bar_length_i, ang: bar_angle_i};
    end
    rd_a_q <= mem[raddr_a_i];
    rd_b_q <= mem[raddr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_gap_q   <= lbpm_pkg::RST_MAX_LENGTH_GAP;
      ang_gap_q   <= lbpm_pkg::RST_MAX_ANGLE_GAP;
      min_ratio_q <= lbpm_pkg::RST_MIN_SPACING_RATIO;
      max_ratio_q <= lbpm_pkg::RST_MAX_SPACING_RATIO;
      hgt_ratio_q <= lbpm_pkg::RST_MAX_HEIGHT_RATIO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbpm_pkg::CFG_MAX_LENGTH_GAP:    len_gap_q   <= cfg_wdata_i;
        lbpm_pkg::CFG_MAX_ANGLE_GAP:     ang_gap_q   <= cfg_wdata_i[lbpm_pkg::AngleGapW-1:0];
        lbpm_pkg::CFG_MIN_SPACING_RATIO: min_ratio_q <= cfg_wdata_i;
        lbpm_pkg::CFG_MAX_SPACING_RATIO: max_ratio_q <= cfg_wdata_i;
        lbpm_pkg::CFG_MAX_HEIGHT_RATIO:  hgt_ratio_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // first checks on the fetched pair
  always_comb begin
    rmax      = (max_ratio_q > min_ratio_q) ? max_ratio_q : min_ratio_q;
    sum_d     = {1'b0, rd_a_q.len} + {1'b0, rd_b_q.len};
    len_delta = (rd_a_q.len > rd_b_q.len) ? rd_a_q.len - rd_b_q.len : rd_b_q.len - rd_a_q.len;
    dx_d      = (rd_a_q.x > rd_b_q.x) ? rd_a_q.x - rd_b_q.x : rd_b_q.x - rd_a_q.x;
    dy_d      = (rd_a_q.y > rd_b_q.y) ? rd_a_q.y - rd_b_q.y : rd_b_q.y - rd_a_q.y;
    ang_d     = $signed({rd_a_q.ang[lbpm_pkg::AngW-1], rd_a_q.ang})
              - $signed({rd_b_q.ang[lbpm_pkg::AngW-1], rd_b_q.ang});
    ang_abs   = (ang_d < 0) ? -ang_d : ang_d;
    ang_w     = (ang_abs > lbpm_pkg::ANGLE_HALF) ? lbpm_pkg::ANGLE_FULL - ang_abs : ang_abs;
    first_bad = (sum_d == '0) || (len_delta > len_gap_q)
             || (ang_w > $signed({3'b000, ang_gap_q}));
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.step)
      lbpm_pkg::STEP_M_DX: begin
        op_a = {1'b0, dx_q};
        op_b = {1'b0, dx_q};
      end
      lbpm_pkg::STEP_M_DY: begin
        op_a = {1'b0, dy_q};
        op_b = {1'b0, dy_q};
      end
      lbpm_pkg::STEP_M_MIN: begin
        op_a = {1'b0, min_ratio_q};
        op_b = sum_q;
      end
      lbpm_pkg::STEP_M_MAX: begin
        op_a = {1'b0, rmax};
        op_b = sum_q;
      end
      lbpm_pkg::STEP_M_HGT: begin
        op_a = sum_q;
        op_b = {1'b0, hgt_ratio_q};
      end
      lbpm_pkg::STEP_SQ_MIN_L: begin
        op_a = rsmin_q[16:0];
        op_b = rsmin_q[16:0];
      end
      lbpm_pkg::STEP_SQ_MIN_M: begin
        op_a = {1'b0, rsmin_q[32:17]};
        op_b = rsmin_q[16:0];
      end
      lbpm_pkg::STEP_SQ_MIN_H: begin
        op_a = {1'b0, rsmin_q[32:17]};
        op_b = {1'b0, rsmin_q[32:17]};
      end
      lbpm_pkg::STEP_SQ_MAX_L: begin
        op_a = rsmax_q[16:0];
        op_b = rsmax_q[16:0];
      end
      lbpm_pkg::STEP_SQ_MAX_M: begin
        op_a = {1'b0, rsmax_q[32:17]};
        op_b = rsmax_q[16:0];
      end
      lbpm_pkg::STEP_SQ_MAX_H: begin
        op_a = {1'b0, rsmax_q[32:17]};
        op_b = {1'b0, rsmax_q[32:17]};
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_ext = lbpm_pkg::SqW'(prod_q);
    scaled   = lbpm_pkg::SqW'({dist_q, 18'b0});
    sq_sum   = acc_q + (prod_ext << 34);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (cmd_i.step)
      lbpm_pkg::STEP_EVAL: begin
        sum_q <= sum_d;
        dx_q  <= dx_d;
        dy_q  <= dy_d;
        rej_q <= first_bad;
      end
      lbpm_pkg::STEP_M_DY:  dist_q  <= lbpm_pkg::RsW'(prod_q);
      lbpm_pkg::STEP_M_MIN: dist_q  <= dist_q + lbpm_pkg::RsW'(prod_q);
      lbpm_pkg::STEP_M_MAX: rsmin_q <= lbpm_pkg::RsW'(prod_q);
      lbpm_pkg::STEP_M_HGT: rsmax_q <= lbpm_pkg::RsW'(prod_q);
      lbpm_pkg::STEP_SQ_MIN_L: begin
        if ({9'b0, dy_q, 9'b0} > prod_q) rej_q <= 1'b1;
      end
      lbpm_pkg::STEP_SQ_MIN_M: acc_q <= prod_ext;
      lbpm_pkg::STEP_SQ_MIN_H: acc_q <= acc_q + (prod_ext << 18);
      lbpm_pkg::STEP_SQ_MAX_L: begin
        if (sq_sum > scaled) rej_q <= 1'b1;
      end
      lbpm_pkg::STEP_SQ_MAX_M: acc_q <= prod_ext;
      lbpm_pkg::STEP_SQ_MAX_H: acc_q <= acc_q + (prod_ext << 18);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      count_q <= '0;
    end else if (cmd_i.step == lbpm_pkg::STEP_FINISH && !rej_q && !(sq_sum < scaled)
                 && count_q != lbpm_pkg::COUNT_MAX) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign pair_count_o = count_q;

endmodule

FILE: design/lbpm_ctrl.sv
// ----------------------------------------------------------------------------
// lbpm_ctrl: bar loading and pair walk sequencer
// Tracks the fill level, walks pairs i<j and steps the datapath per pair.
// ----------------------------------------------------------------------------
module lbpm_ctrl #(
  parameter int unsigned MAX_BARS = 32,
  localparam int unsigned AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1,
  localparam int unsigned CW = $clog2(MAX_BARS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           last_bar_i,
  output logic           busy,
  output logic           done_o,
  output logic           bars_dropped_o,
  output lbpm_pkg::cmd_t cmd_o,
  output logic [AW-1:0]  waddr_o,
  output logic [AW-1:0]  raddr_a_o,
  output logic [AW-1:0]  raddr_b_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC
  } state_e;

  state_e              state_q;
  lbpm_pkg::step_e     step_q;
  logic [CW-1:0]       held_q;
  logic                ovf_q;
  logic [AW-1:0]       i_q, j_q;
  logic                done_q, dropped_q;

  logic          accept, full;
  logic [CW-1:0] n_bars, j_next, i_next2;

  always_comb begin
    accept  = start && (state_q == ST_IDLE);
    full    = (held_q == CW'(MAX_BARS));
    n_bars  = full ? held_q : held_q + CW'(1);
    j_next  = CW'(j_q) + CW'(1);
    i_next2 = CW'(i_q) + CW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= lbpm_pkg::STEP_EVAL;
      held_q    <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      done_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (last_bar_i) begin
              if (n_bars < CW'(2)) begin
                done_q    <= 1'b1;
                dropped_q <= ovf_q || full;
                held_q    <= '0;
                ovf_q     <= 1'b0;
              end else begin
                held_q  <= n_bars;
                ovf_q   <= ovf_q || full;
                i_q     <= '0;
                j_q     <= AW'(1);
                state_q <= ST_FETCH;
              end
            end else if (full) begin
              ovf_q <= 1'b1;
            end else begin
              held_q <= n_bars;
            end
          end
        end
        ST_FETCH: begin
          step_q  <= lbpm_pkg::STEP_EVAL;
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          step_q <= lbpm_pkg::next_step(step_q);
          if (step_q == lbpm_pkg::STEP_FINISH) begin
            if (j_next < held_q) begin
              j_q     <= AW'(j_next);
              state_q <= ST_FETCH;
            end else if (i_next2 < held_q) begin
              i_q     <= i_q + AW'(1);
              j_q     <= AW'(i_next2);
              state_q <= ST_FETCH;
            end else begin
              done_q    <= 1'b1;
              dropped_q <= ovf_q;
              held_q    <= '0;
              ovf_q     <= 1'b0;
              state_q   <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.mem_we  = accept && !full;
    cmd_o.cnt_clr = accept && last_bar_i;
    cmd_o.step    = (state_q == ST_CALC) ? step_q : lbpm_pkg::STEP_NONE;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign bars_dropped_o = dropped_q;
  assign waddr_o        = AW'(held_q);
  assign raddr_a_o      = i_q;
  assign raddr_b_o      = j_q;

endmodule

FILE: design/light_bar_pair_matcher_core.sv
// ----------------------------------------------------------------------------
// light_bar_pair_matcher_core: counts matching light bar pairs of a frame
//
//   channel | handshake         | payload
//   --------+-------------------+----------------------------------------------
//   bar in  | start, busy       | center_x_i center_y_i bar_length_i
//           |                   | bar_angle_i last_bar_i
//   result  | done_o (strobe)   | pair_count_o bars_dropped_o
//   config  | cfg_we_i          | cfg_idx_i cfg_wdata_i
//
// a bar that is not last is stored, or dropped when full; busy stays low
// the last bar of n stored bars starts the pair walk over all n*(n-1)/2 pairs,
//   one pair at a time, stepped through the one shared 17x17 multiplier
// done_o shows the result for one cycle, the next frame may start then
// reset clears fill level, walk state and pair count, loads config reset values, no memory sweep
// ----------------------------------------------------------------------------
module light_bar_pair_matcher_core #(
  parameter int unsigned MAX_BARS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [lbpm_pkg::PosW-1:0]        center_x_i,
  input  logic [lbpm_pkg::PosW-1:0]        center_y_i,
  input  logic [lbpm_pkg::PosW-1:0]        bar_length_i,
  input  logic signed [lbpm_pkg::AngW-1:0] bar_angle_i,
  input  logic                             last_bar_i,
  output logic                             done_o,
  output logic [lbpm_pkg::CountW-1:0]      pair_count_o,
  output logic                             bars_dropped_o,
  input  logic                             cfg_we_i,
  input  logic [lbpm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lbpm_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

  lbpm_pkg::cmd_t cmd;
  logic [AW-1:0]  waddr, raddr_a, raddr_b;

  lbpm_ctrl #(
    .MAX_BARS(MAX_BARS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .last_bar_i    (last_bar_i),
    .busy          (busy),
    .done_o        (done_o),
    .bars_dropped_o(bars_dropped_o),
    .cmd_o         (cmd),
    .waddr_o       (waddr),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b)
  );

  lbpm_datapath #(
    .MAX_BARS(MAX_BARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .waddr_i     (waddr),
    .raddr_a_i   (raddr_a),
    .raddr_b_i   (raddr_b),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .bar_length_i(bar_length_i),
    .bar_angle_i (bar_angle_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pair_count_o(pair_count_o)
  );

endmodule

FILE: design/lbpm_checker.sv
// ----------------------------------------------------------------------------
// lbpm_checker: port level checks of the pair matcher
// Timing of busy against accepted transactions and the result strobe.
// ----------------------------------------------------------------------------
module lbpm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_bar_i,
  input logic done_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_plain_bar_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_bar_i) |=> (!busy && !done_o))
    else $error("bar that is not last did not finish in one cycle");

  a_last_bar_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_bar_i) |=> (busy || done_o))
    else $error("last bar neither started the walk nor gave a result");

  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without a result");

endmodule

bind light_bar_pair_matcher_core lbpm_checker u_lbpm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .last_bar_i(last_bar_i),
  .done_o    (done_o)
);
